[hw/rtl/bog_pkg.sv]
// ----------------------------------------------------------------------------
// bog_pkg
// Shared types and constants for the broadcast offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bog_pkg;

  localparam int DIMS         = 4;
  localparam int RANK_DEFAULT = 4;
  localparam int WORD_W       = 32;
  localparam int CFG_INDEX_W  = 4;

  // register index bases: output strides first, then source strides
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_STRIDE_BASE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_STRIDE_BASE = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_END             = 4'd8;

  // one item moving between dimension sections
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] idx;
    logic [WORD_W-1:0] acc;
    logic              ovf;
  } bog_item_t;

endpackage

`default_nettype wire

[hw/rtl/bog_dim.sv]
// ----------------------------------------------------------------------------
// bog_dim
// One dimension: pipelined restoring divide (one quotient bit per stage),
// then a multiply stage and an accumulate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bog_dim
  import bog_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [WORD_W-1:0] out_stride,
  input  wire logic [WORD_W-1:0] src_stride,
  input  wire bog_item_t         din,
  output bog_item_t              dout
);

  localparam int QW = 2 * WORD_W;

  // divider stage registers: upper half remainder, lower half dividend/quotient
  logic              dv_valid [WORD_W+1];
  logic [QW-1:0]     dv_rq    [WORD_W+1];
  logic [WORD_W-1:0] dv_acc   [WORD_W+1];
  logic              dv_ovf   [WORD_W+1];

  assign dv_valid[0] = din.valid;
  assign dv_rq[0]    = {{WORD_W{1'b0}}, din.idx};
  assign dv_acc[0]   = din.acc;
  assign dv_ovf[0]   = din.ovf;

  for (genvar k = 0; k < WORD_W; k++) begin : g_div
    logic [QW:0]     shifted;
    logic [WORD_W:0] top;
    logic [WORD_W:0] diff;
    logic            qbit;

    // shift in one dividend bit, trial subtract
    always_comb begin
      shifted = {dv_rq[k], 1'b0};
      top     = shifted[QW:WORD_W];
      diff    = top - {1'b0, out_stride};
      qbit    = (top >= {1'b0, out_stride});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rq[k+1]  <= {(qbit ? diff[WORD_W-1:0] : top[WORD_W-1:0]),
                        shifted[WORD_W-1:1], qbit};
        dv_acc[k+1] <= dv_acc[k];
        dv_ovf[k+1] <= dv_ovf[k];
      end
    end
  end

  // multiply stage: coordinate times source stride
  logic [WORD_W-1:0] coord;
  logic              mu_valid;
  logic [QW-1:0]     mu_prod;
  logic [WORD_W-1:0] mu_rem;
  logic [WORD_W-1:0] mu_acc;
  logic              mu_ovf;

  // zero output stride gives coordinate zero, remainder is the index
  assign coord = (out_stride == '0) ? '0 : dv_rq[WORD_W][WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (adv) begin
      mu_valid <= dv_valid[WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_prod <= coord * src_stride;
      mu_rem  <= dv_rq[WORD_W][QW-1:WORD_W];
      mu_acc  <= dv_acc[WORD_W];
      mu_ovf  <= dv_ovf[WORD_W];
    end
  end

  // accumulate stage with overflow tracking
  logic [WORD_W:0] sum;
  assign sum = {1'b0, mu_acc} + {1'b0, mu_prod[WORD_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= mu_valid;
    end
    if (adv) begin
      dout.idx <= mu_rem;
      dout.acc <= sum[WORD_W-1:0];
      dout.ovf <= mu_ovf | (mu_prod[QW-1:WORD_W] != '0) | sum[WORD_W];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/broadcast_offset_generator.sv]
// ----------------------------------------------------------------------------
// broadcast_offset_generator
// Maps a flat output index to a source element offset under broadcasting.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  in       in_valid in_ready flat_index     input transaction
//  out      out_valid out_ready              result transaction
//           source_offset overflow
//  cfg      cfg_valid cfg_ready cfg_index    register write
//           cfg_data
//
//  One index per cycle unless the output stalls. Each dimension has a
//  32-stage one-bit-per-stage divider, a multiply stage and an add stage.
//  Synchronous reset clears valid bits and loads the stride defaults.
//  A stall at the output freezes the whole pipeline in lock step.
//  Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_offset_generator
  import bog_pkg::*;
#(
  parameter int RANK = RANK_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [WORD_W-1:0]      flat_index,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [WORD_W-1:0]           source_offset,
  output logic                        overflow,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data
);

  logic [WORD_W-1:0] out_stride [DIMS];
  logic [WORD_W-1:0] src_stride [DIMS];
  logic              adv;

  assign cfg_ready = 1'b1;

  // stride registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DIMS; d++) begin
        out_stride[d] <= (d == DIMS - 1) ? WORD_W'(1) : '0;
        src_stride[d] <= (d == DIMS - 1) ? WORD_W'(1) : '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index < CFG_SRC_STRIDE_BASE) begin
        out_stride[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index < CFG_END) begin
        src_stride[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  // lock-step advance: the last stage is the output register
  bog_item_t link [RANK+1];

  assign adv      = !link[RANK].valid || out_ready;
  assign in_ready = adv;

  assign link[0] = '{valid: in_valid, idx: flat_index, acc: '0, ovf: 1'b0};

  for (genvar g = 0; g < RANK; g++) begin : g_dim
    bog_dim u_dim (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .out_stride (out_stride[DIMS-RANK+g]),
      .src_stride (src_stride[DIMS-RANK+g]),
      .din        (link[g]),
      .dout       (link[g+1])
    );
  end

  assign out_valid     = link[RANK].valid;
  assign source_offset = link[RANK].acc;
  assign overflow      = link[RANK].ovf;

  // checks
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_offset))
    else $error("stalled result changed");

endmodule

`default_nettype wire

[sim/broadcast_offset_generator_test.sv]
// ----------------------------------------------------------------------------
// broadcast_offset_generator_test
// Self-checking bench for the broadcast offset generator. A driver and a
// monitor run as clocked processes. Stride registers are reloaded between
// phases, and each index transaction is predicted from a local copy of
// the strides. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module broadcast_offset_generator_test;
  import bog_pkg::*;

  localparam int PIPE_DELAY  = 34 * DIMS + 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_CFG     = 8;

  typedef struct packed {
    logic [WORD_W-1:0] offset;
    logic              ovf;
  } offset_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [WORD_W-1:0]      flat_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [WORD_W-1:0]      source_offset;
  logic                   overflow;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;

  // local copy of the stride registers
  logic [WORD_W-1:0] out_stride_m [DIMS];
  logic [WORD_W-1:0] src_stride_m [DIMS];

  logic [WORD_W-1:0] pending_index_q [$];
  offset_result_t    expected_offset_q [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                quiet = 1'b0;
  int                send_gap = 0;
  int                recv_gap = 0;

  broadcast_offset_generator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .flat_index(flat_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .source_offset(source_offset), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // walk dimensions outermost first, accumulating the source offset
  function automatic offset_result_t compute_offset(logic [WORD_W-1:0] index);
    offset_result_t    r;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] coord;
    logic [63:0]       prod;
    logic [32:0]       sum;
    rem = index;
    r.offset = '0;
    r.ovf = 1'b0;
    for (int d = DIMS - RANK_DEFAULT; d < DIMS; d++) begin
      coord = (out_stride_m[d] == 0) ? '0 : rem / out_stride_m[d];
      rem = rem - coord * out_stride_m[d];
      prod = {32'd0, coord} * {32'd0, src_stride_m[d]};
      if (prod[63:32] != 0) r.ovf = 1'b1;
      sum = {1'b0, r.offset} + {1'b0, prod[31:0]};
      if (sum[32]) r.ovf = 1'b1;
      r.offset = sum[31:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // append one index to the pending queue
  task automatic queue_index(input logic [WORD_W-1:0] v);
    pending_index_q = {pending_index_q, v};
  endtask

  // driver: index transactions
  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_offset_q = {expected_offset_q, compute_offset(flat_index)};
        next_valid = 1'b0;
        send_gap = pick_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_index_q.size() > 0) begin
          flat_index <= pending_index_q.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // monitor: result transactions
  always @(posedge clk) begin
    offset_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_offset_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result offset=%h overflow=%b", source_offset, overflow);
        end else begin
          want = expected_offset_q.pop_front();
          if (want.offset !== source_offset || want.ovf !== overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected offset=%h overflow=%b, got offset=%h overflow=%b",
                       want.offset, want.ovf, source_offset, overflow);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // write all stride registers, then one unknown index that must be ignored
  task automatic load_strides(input logic [WORD_W-1:0] o [DIMS],
                              input logic [WORD_W-1:0] s [DIMS]);
    logic [WORD_W-1:0] value;
    for (int i = 0; i <= NUM_CFG; i++) begin
      if (i < DIMS) value = o[i];
      else if (i < NUM_CFG) value = s[i - DIMS];
      else value = $urandom;
      cfg_valid <= 1'b1;
      cfg_index <= (i < NUM_CFG) ? CFG_INDEX_W'(CFG_OUT_STRIDE_BASE + i)
                                 : CFG_INDEX_W'(CFG_END + $urandom_range(0, 7));
      cfg_data  <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i < DIMS) out_stride_m[i] = value;
      else if (i < NUM_CFG) src_stride_m[i - DIMS] = value;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_index_q.size() > 0 || in_valid || expected_offset_q.size() > 0)
      @(posedge clk);
    repeat (PIPE_DELAY) @(posedge clk);
  endtask

  initial begin
    logic [WORD_W-1:0] o [DIMS];
    logic [WORD_W-1:0] s [DIMS];
    logic [WORD_W-1:0] extent [DIMS];
    logic [WORD_W-1:0] total;
    for (int d = 0; d < DIMS; d++) begin
      out_stride_m[d] = '0;
      src_stride_m[d] = '0;
    end
    out_stride_m[DIMS-1] = 1;
    src_stride_m[DIMS-1] = 1;
    total = '1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset strides: offset equals index
    queue_index(32'h0);
    queue_index(32'hFFFF_FFFF);
    queue_index(32'h8000_0000);
    queue_index($urandom);
    wait_idle();

    // all strides at maximum: coordinates stay at most one, so nothing overflows
    o = '{default: 32'hFFFF_FFFF};
    s = '{default: 32'hFFFF_FFFF};
    load_strides(o, s);
    queue_index(32'hFFFF_FFFF);
    queue_index(32'hFFFF_FFFE);
    queue_index(32'h0);
    wait_idle();

    // zero output strides everywhere but the innermost, huge source stride
    o = '{32'h0, 32'h0, 32'h0, 32'h1};
    s = '{32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF};
    load_strides(o, s);
    queue_index(32'h1);
    queue_index(32'h2);
    queue_index(32'hFFFF_FFFF);
    wait_idle();

    // all zero: every coordinate is zero
    o = '{default: 32'h0};
    s = '{default: 32'h0};
    load_strides(o, s);
    queue_index(32'hFFFF_FFFF);
    queue_index(32'h5555_AAAA);
    wait_idle();

    // sum overflow without product overflow, then an index whose products overflow
    o = '{32'h0, 32'h0, 32'h100, 32'h1};
    s = '{32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000};
    load_strides(o, s);
    queue_index(32'h101);
    queue_index(32'h100);
    queue_index(32'h1);
    queue_index(32'h2FF);
    wait_idle();

    // random phases, mostly well formed broadcast shapes
    for (int phase = 0; phase < 12; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        for (int d = 0; d < DIMS; d++) begin
          o[d] = $urandom;
          s[d] = $urandom;
          if ($urandom_range(0, 3) == 0) o[d] = '0;
        end
        total = '1;
      end else begin
        for (int d = 0; d < DIMS; d++) extent[d] = $urandom_range(1, 12);
        o[DIMS-1] = 1;
        for (int d = DIMS - 2; d >= 0; d--) o[d] = o[d+1] * extent[d+1];
        total = o[0] * extent[0];
        if ($urandom_range(0, 1) == 0) o[0] = '0;
        for (int d = 0; d < DIMS; d++)
          s[d] = ($urandom_range(0, 2) == 0) ? '0
               : ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 4096);
      end
      load_strides(o, s);
      for (int i = 0; i < 40; i++)
        queue_index(($urandom_range(0, 4) == 0) ? $urandom
                    : $urandom_range(0, total - 1));
      wait_idle();
    end

    if (mismatch_count == 0 && expected_offset_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
